>>> rtl/sdr_pkg.sv
package sdr_pkg;

	// Width of the element field on both channels.
	localparam int unsigned DATA_W = 32;
	// Width of the distinct count field on the result channel.
	localparam int unsigned COUNT_W = 7;

	// Default store depth and compared width of an element.
	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// A request as it travels down the chain of cells.
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic                     hit;   // matched a stored value in some cell passed so far
		logic                     kept;  // stored in a free cell passed so far
		logic signed [DATA_W-1:0] value;
	} sdr_tok_t;

endpackage

>>> rtl/sdr_if.sv
interface sdr_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [sdr_pkg::DATA_W-1:0] value;
	logic                              last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface sdr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [sdr_pkg::DATA_W-1:0]  value_out;
	logic                               keep;
	logic        [sdr_pkg::COUNT_W-1:0] distinct_count;
	logic                               overflow;
	logic                               last_out;

	modport source (output valid, output value_out, output keep, output distinct_count,
		output overflow, output last_out, input ready);
	modport sink (input valid, input value_out, input keep, input distinct_count,
		input overflow, input last_out, output ready);
endinterface

>>> rtl/sdr_cell.sv
module sdr_cell #(
	parameter int unsigned KEY_BITS = 32,
	parameter int unsigned CNT_W    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  sdr_pkg::sdr_tok_t tok_in,
	input  logic [CNT_W-1:0]  cnt_in,
	output sdr_pkg::sdr_tok_t tok_out,
	output logic [CNT_W-1:0]  cnt_out
);

	logic              occ_q;
	logic [KEY_BITS-1:0] val_q;
	sdr_pkg::sdr_tok_t tok_q;
	logic [CNT_W-1:0]  cnt_q;

	logic                key;
	logic [KEY_BITS-1:0] key_in;
	logic                store;
	sdr_pkg::sdr_tok_t   tok_d;
	logic [CNT_W-1:0]    cnt_d;

	// An empty cell takes the first request that reaches it neither matched nor already
	// stored; every request ahead of it in the same array has already settled this cell.
	always_comb begin
		key_in = tok_in.value[KEY_BITS-1:0];
		key    = tok_in.valid && occ_q && (val_q == key_in);
		store  = tok_in.valid && !occ_q && !tok_in.hit && !tok_in.kept;
		tok_d      = tok_in;
		tok_d.hit  = tok_in.hit | key;
		tok_d.kept = tok_in.kept | store;
		cnt_d      = cnt_in + CNT_W'(occ_q | store);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			tok_q <= tok_d;
			cnt_q <= cnt_d;
			// The final request of an array empties each cell as it passes.
			if (tok_in.valid && tok_in.last) begin
				occ_q <= 1'b0;
			end else if (store) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store) begin
			val_q <= key_in;
		end
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

>>> rtl/stable_duplicate_removal.sv
// Path: an accepted request passes through the CAPACITY cell registers in order, one cell per step.
// Throughput: one request per cycle; the whole chain moves together and halts while a
// result waits at the end of the chain without being taken.
// Reset: arst_n clears every cell's occupancy and the request valid flags at once;
// the block takes requests from the first cycle after reset.
module stable_duplicate_removal #(
	parameter int unsigned CAPACITY   = sdr_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = sdr_pkg::VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sdr_in_if.sink    request,
	sdr_out_if.source result
);

	// Only the low VALUE_BITS of an element take part in the comparison, and the
	// element field is never wider than DATA_W.
	localparam int unsigned KEY_BITS =
		(VALUE_BITS < sdr_pkg::DATA_W) ? VALUE_BITS : sdr_pkg::DATA_W;
	// The running count reaches CAPACITY at most.
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// Element i of these arrays is what enters cell i; the last element is what leaves
	// the final cell and forms the result register.
	sdr_pkg::sdr_tok_t tok [0:CAPACITY];
	logic [CNT_W-1:0]  cnt [0:CAPACITY];

	logic                          advance;
	logic [CNT_W+sdr_pkg::COUNT_W-1:0] cnt_wide;

	// The chain steps whenever the result register is empty or being taken. Each request
	// moves one cell per step, comparing its element with the value held there. A
	// request that meets an occupied cell holding its value is a repeat; one that meets
	// an empty cell first takes that cell and is kept. Since cells fill from the front,
	// the number of occupied cells a request passes is the distinct count after it.
	assign advance       = !result.valid || result.ready;
	assign request.ready = advance;

	assign tok[0] = '{
		valid: request.valid,
		last:  request.last,
		hit:   1'b0,
		kept:  1'b0,
		value: request.value
	};
	assign cnt[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sdr_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok[i]),
			.cnt_in  (cnt[i]),
			.tok_out (tok[i+1]),
			.cnt_out (cnt[i+1])
		);
	end

	// A new value that passed every cell without finding a match or a free cell found
	// the store full; it is reported as overflow and nothing is stored.
	assign cnt_wide              = {{sdr_pkg::COUNT_W{1'b0}}, cnt[CAPACITY]};
	assign result.valid          = tok[CAPACITY].valid;
	assign result.value_out      = tok[CAPACITY].value;
	assign result.keep           = tok[CAPACITY].kept;
	assign result.overflow       = !tok[CAPACITY].hit && !tok[CAPACITY].kept;
	assign result.last_out       = tok[CAPACITY].last;
	assign result.distinct_count = cnt_wide[sdr_pkg::COUNT_W-1:0];

	// An accepted request is in the first cell after the next edge.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> tok[1].valid)
		else $error("accepted request did not enter the chain");

	// While a result waits, the chain holds and takes no new request.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !request.ready)
		else $error("request taken while the result register is stalled");

	// A request is never both a repeat and stored.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(tok[CAPACITY].hit && tok[CAPACITY].kept))
		else $error("request both matched and stored");

	// A kept value counts itself, so the count of a kept result is never zero.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.keep |-> (cnt[CAPACITY] != '0))
		else $error("kept result with a zero distinct count");

endmodule

>>> dv/tb_stable_duplicate_removal.sv
`timescale 1ns / 100ps

module tb_stable_duplicate_removal;

	// Field widths shared with the block.
	localparam int unsigned DATA_W  = sdr_pkg::DATA_W;
	localparam int unsigned COUNT_W = sdr_pkg::COUNT_W;

	// The block is built with its default store depth and compared width.
	localparam int unsigned CAPACITY   = sdr_pkg::CAPACITY_DEF;
	localparam int unsigned VALUE_BITS = sdr_pkg::VALUE_BITS_DEF;

	// Only the low VALUE_BITS of an element take part in the comparison.
	localparam logic [DATA_W-1:0] VALUE_MASK =
		(VALUE_BITS >= DATA_W) ? '1 : DATA_W'((64'd1 << VALUE_BITS) - 64'd1);

	// Least number of random requests to send after the directed part; whole arrays are sent.
	localparam int unsigned RANDOM_ELEMENTS = 1530;
	// How long the receiver refuses results when asked to back up the chain.
	localparam int unsigned LONG_HOLD_CYCLES = 320;
	// Hard ceiling on the whole run, far beyond the slowest legal run.
	localparam int unsigned RUN_LIMIT_NS = 4_000_000;

	// One result as the block should present it.
	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic                     keep;
		logic [COUNT_W-1:0]       distinct_count;
		logic                     overflow;
		logic                     last_out;
	} dedup_result_t;

	// The shapes of array that the random part draws from.
	typedef enum int unsigned {
		ARR_POOL,   // short, values from a narrow pool, so repeats are common
		ARR_MIXED,  // medium length, repeats mixed with arbitrary values
		ARR_FILL,   // long enough to fill the store and run into overflow
		ARR_NOISE   // arbitrary bit patterns, hardly ever a repeat
	} array_shape_t;

	// The scoreboard keeps its own copy of the distinct-value store. Every accepted
	// request is run through it at once, and the verdict it yields waits in a queue
	// until the block delivers the matching result.
	class dedup_scoreboard;
		logic [DATA_W-1:0] seen [CAPACITY];
		int unsigned       held;
		dedup_result_t     verdicts_due [$];
		int unsigned       failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		function int unsigned outstanding();
			return verdicts_due.size();
		endfunction

		function void note_element(logic signed [DATA_W-1:0] value, logic last);
			dedup_result_t verdict;
			logic [DATA_W-1:0] key;
			bit found;
			int unsigned i;
			key = value & VALUE_MASK;
			found = 0;
			for (i = 0; i < held; i++) begin
				if (seen[i] == key)
					found = 1;
			end
			verdict.value_out = value;
			verdict.keep = 1'b0;
			verdict.overflow = 1'b0;
			// A new value is stored while there is room; once the store is full it is
			// refused, and so is every later repeat of it, since it was never stored.
			if (!found) begin
				if (held < CAPACITY) begin
					seen[held] = key;
					held++;
					verdict.keep = 1'b1;
				end else begin
					verdict.overflow = 1'b1;
				end
			end
			verdict.distinct_count = COUNT_W'(held);
			verdict.last_out = last;
			verdicts_due.push_back(verdict);
			// The final element forms its result first and then empties the store.
			if (last)
				held = 0;
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			failures++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_verdict(dedup_result_t got);
			dedup_result_t want;
			if (verdicts_due.size() == 0) begin
				failures++;
				$display("%0t ns: result with none expected, actual %0h", $time, got);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.value_out !== want.value_out)
				report("value_out", want.value_out, got.value_out);
			if (got.keep !== want.keep)
				report("keep", want.keep, got.keep);
			if (got.distinct_count !== want.distinct_count)
				report("distinct_count", want.distinct_count, got.distinct_count);
			if (got.overflow !== want.overflow)
				report("overflow", want.overflow, got.overflow);
			if (got.last_out !== want.last_out)
				report("last_out", want.last_out, got.last_out);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sdr_in_if  request_ch ();
	sdr_out_if result_ch ();

	dedup_scoreboard sb;

	// When set, each side sends or takes without any pause of its own.
	bit tx_free;
	bit rx_free;
	// Set by the stimulus to make the receiver stop taking results for a long stretch.
	bit long_hold_req;

	stable_duplicate_removal #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Anything still running at this point has hung.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Both handshakes are observed at the rising edge. The result is checked before the
	// request of the same edge is noted: with a chain this deep a result can never
	// belong to a request accepted in the same cycle.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_verdict({result_ch.value_out, result_ch.keep,
					result_ch.distinct_count, result_ch.overflow, result_ch.last_out});
			if (request_ch.valid && request_ch.ready)
				sb.note_element(request_ch.value, request_ch.last);
		end
	end

	// Offer one request, after a random pause unless the sender runs free, and return
	// at the edge where the block takes it. Valid is left high; the next call, a drain
	// or the end of the run decides at the following falling edge what it becomes.
	task automatic send_element(input logic signed [DATA_W-1:0] value, input logic last);
		int unsigned gap;
		gap = tx_free ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap != 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_ch.value <= value;
		request_ch.last <= last;
		request_ch.valid <= 1'b1;
		do @(posedge clk); while (!request_ch.ready);
	endtask

	// Withdraw the request and wait until every result owed has been delivered.
	task automatic wait_drained();
		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// One well-formed array of random shape and content; its length is handed back.
	task automatic send_random_array(output int unsigned length);
		array_shape_t shape;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] value;
		int unsigned fresh;
		int unsigned i;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: shape = ARR_POOL;
			6, 7: shape = ARR_MIXED;
			8: shape = ARR_FILL;
			default: shape = ARR_NOISE;
		endcase
		case (shape)
			ARR_POOL: length = $urandom_range(1, 16);
			ARR_MIXED: length = $urandom_range(17, 48);
			ARR_FILL: length = $urandom_range(80, 110);
			default: length = $urandom_range(1, 24);
		endcase
		base = $urandom;
		fresh = 0;
		for (i = 0; i < length; i++) begin
			case (shape)
				ARR_POOL: value = base + DATA_W'($urandom_range(0, 7));
				ARR_MIXED: value = $urandom_range(0, 1) ? base + DATA_W'($urandom_range(0, 23))
					: DATA_W'($urandom);
				// Mostly fresh values, so the store fills up, with repeats of values both
				// stored and refused thrown in along the way.
				ARR_FILL: begin
					if (fresh < CAPACITY + 8 && $urandom_range(0, 4) != 0) begin
						value = base + DATA_W'(fresh);
						fresh++;
					end else begin
						value = base + DATA_W'($urandom_range(0, CAPACITY + 7));
					end
				end
				default: value = $urandom;
			endcase
			send_element(value, i == length - 1);
		end
	endtask

	// The receiver takes one result after each pause it draws. On request it refuses
	// results for a long stretch, counted here, so that the chain backs up to the input.
	initial begin
		int unsigned gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD_CYCLES;
			end else begin
				gap = rx_free ? 0 : $urandom_range(0, 13);
			end
			@(negedge clk);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin
		int unsigned sent;
		int unsigned length;
		int unsigned i;
		sb = new();
		tx_free = 1'b0;
		rx_free = 1'b0;
		long_hold_req = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.value = '0;
		request_ch.last = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A single-element array.
		send_element(32'sh0000_0000, 1'b1);
		// The extremes of the element, a repeat straight after its first occurrence,
		// a repeat further on, and a repeat as the final element.
		send_element(32'sh8000_0000, 1'b0);
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(32'sh0000_0000, 1'b0);
		send_element(32'shffff_ffff, 1'b0);
		send_element(32'shffff_ffff, 1'b0);
		send_element(32'sh8000_0000, 1'b0);
		send_element(32'sh0000_0000, 1'b0);
		send_element(32'sh0000_0005, 1'b0);
		send_element(32'sh0000_0005, 1'b1);
		// The store was cleared by the final element, so this value is new again.
		send_element(32'sh0000_0005, 1'b1);
		// Values that differ only in the sign bit must not be taken for each other.
		send_element(32'sh0000_0001, 1'b0);
		send_element(32'sh8000_0001, 1'b0);
		send_element(32'sh0000_0001, 1'b1);
		wait_drained();

		// Back-pressure: the sender runs flat out while the receiver holds off, so the
		// chain fills and the input stalls. The array itself fills the store, refuses
		// the values after that, and then repeats both stored and refused values.
		tx_free = 1'b1;
		rx_free = 1'b1;
		long_hold_req = 1'b1;
		for (i = 0; i < 100; i++)
			send_element((i < CAPACITY + 6) ? DATA_W'(i) : DATA_W'(60 + i % 12), i == 99);
		tx_free = 1'b0;
		rx_free = 1'b0;
		// The sender now pauses until the block has handed back everything.
		wait_drained();

		// Random arrays, with the idling of each side chosen afresh for each array and
		// the odd pause until the block is empty.
		sent = 0;
		while (sent < RANDOM_ELEMENTS) begin
			tx_free = ($urandom_range(0, 3) == 0);
			rx_free = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			send_random_array(length);
			sent += length;
		end
		wait_drained();
		// Give a stray extra result time to show itself.
		repeat (2 * CAPACITY + 16) @(posedge clk);

		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
